>>> design/fxa_pkg.sv
// fxa_pkg: shared types and constants of the fixed-point alu
// no dependencies
`default_nettype none

package fxa_pkg;

    localparam int unsigned FractionBitsDefault = 8;

    typedef enum logic [3:0] {
        FUNC_ADD  = 4'd0,
        FUNC_SUB  = 4'd1,
        FUNC_MUL  = 4'd2,
        FUNC_DIV  = 4'd3,
        FUNC_GT   = 4'd4,
        FUNC_LT   = 4'd5,
        FUNC_GE   = 4'd6,
        FUNC_LE   = 4'd7,
        FUNC_EQ   = 4'd8,
        FUNC_NE   = 4'd9,
        FUNC_MIN  = 4'd10,
        FUNC_MAX  = 4'd11,
        FUNC_INC  = 4'd12,
        FUNC_DEC  = 4'd13,
        FUNC_FINT = 4'd14,
        FUNC_NOP  = 4'd15
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_OVF  = 2'd1,
        STATUS_DIV0 = 2'd2,
        STATUS_RSVD = 2'd3
    } status_t;

endpackage

`default_nettype wire

>>> design/fxa_if.sv
// fxa_req_if, fxa_rsp_if: valid/ready channels of the fixed-point alu
// depends on nothing
`default_nettype none

interface fxa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output func, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input func, input operand_a, input operand_b,
                    output ready);
endinterface

interface fxa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               flag;
    logic [1:0]         status;

    modport source (output valid, output result, output flag, output status,
                    input ready);
    modport sink   (input valid, input result, input flag, input status,
                    output ready);
endinterface

`default_nettype wire

>>> design/fixed_point_alu.sv
// fixed_point_alu: pipelined signed 32-bit fixed-point alu
// depends on fxa_pkg and the channel interfaces in fxa_if.sv
`default_nettype none

//  channel | direction | transfer carries
//  --------+-----------+--------------------------------------
//  req     | in        | func, operand_a, operand_b
//  rsp     | out       | result, flag, status
//
// one item may enter every cycle while rsp does not stall; each result is
// registered in every stage of the pipe in order before it leaves on rsp
// the depth is set by the divider: 32 restoring steps, 4 per stage, 8 stages
// between an operand stage and a final sign/saturation stage
// a stall on rsp freezes the whole pipe and drops req.ready; nothing is lost
// reset clears the valid bits only

module fixed_point_alu #(
    parameter int unsigned FRACTION_BITS = fxa_pkg::FractionBitsDefault
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fxa_req_if.sink    req,
    fxa_rsp_if.source  rsp
);

    localparam int unsigned StepsPerStage = 4;
    localparam int unsigned DivStages     = 32 / StepsPerStage;
    localparam int unsigned Stages        = DivStages + 1;
    localparam logic [63:0] Half          = (64'd1 << FRACTION_BITS) >> 1;
    localparam logic signed [63:0] Max32  = 64'sd2147483647;
    localparam logic signed [63:0] Min32  = -64'sd2147483648;

    typedef struct packed {
        fxa_pkg::func_t     func;
        logic               flag;
        logic               div_zero;
        logic               div_ovf;
        logic               neg;
        logic signed [63:0] val;
        logic [33:0]        den;
        logic [33:0]        rem;
        logic [31:0]        num;
    } stage_t;

    // whole pipe moves together when the output slot is free or being taken
    logic adv;
    assign adv       = !rsp.valid || rsp.ready;
    assign req.ready = adv;

    stage_t st_reg  [Stages];
    logic   vld_reg [Stages];
    stage_t st_next [Stages];

    // operand stage
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic [32:0]        mag_a;
    logic [32:0]        mag_b;
    logic [63:0]        numer;

    always_comb
    begin
        a      = req.operand_a;
        b      = req.operand_b;
        a64    = 64'(a);
        b64    = 64'(b);
        mag_a  = a[31] ? (~{a[31], a} + 33'd1) : {1'b0, a};
        mag_b  = b[31] ? (~{b[31], b} + 33'd1) : {1'b0, b};
        // rounded quotient is floor((2n + d) / 2d) with n = |a| << F, d = |b|
        numer  = ((64'(mag_a) << FRACTION_BITS) << 1) + 64'(mag_b);

        st_next[0]          = '0;
        st_next[0].func     = fxa_pkg::func_t'(req.func);
        st_next[0].den      = {mag_b, 1'b0};
        st_next[0].rem      = {2'b00, numer[63:32]};
        st_next[0].num      = numer[31:0];
        st_next[0].div_zero = (b == 32'sd0);
        st_next[0].div_ovf  = ({2'b00, numer[63:32]} >= {mag_b, 1'b0});
        st_next[0].neg      = a[31] ^ b[31];
        unique case (fxa_pkg::func_t'(req.func))
            fxa_pkg::FUNC_ADD:  st_next[0].val = a64 + b64;
            fxa_pkg::FUNC_SUB:  st_next[0].val = a64 - b64;
            fxa_pkg::FUNC_MUL:  st_next[0].val = a64 * b64;
            fxa_pkg::FUNC_GT:   st_next[0].flag = (a > b);
            fxa_pkg::FUNC_LT:   st_next[0].flag = (a < b);
            fxa_pkg::FUNC_GE:   st_next[0].flag = (a >= b);
            fxa_pkg::FUNC_LE:   st_next[0].flag = (a <= b);
            fxa_pkg::FUNC_EQ:   st_next[0].flag = (a == b);
            fxa_pkg::FUNC_NE:   st_next[0].flag = (a != b);
            fxa_pkg::FUNC_MIN:  st_next[0].val = (a < b) ? a64 : b64;
            fxa_pkg::FUNC_MAX:  st_next[0].val = (a > b) ? a64 : b64;
            fxa_pkg::FUNC_INC:  st_next[0].val = a64 + 64'sd1;
            fxa_pkg::FUNC_DEC:  st_next[0].val = a64 - 64'sd1;
            fxa_pkg::FUNC_FINT: st_next[0].val = a64 <<< FRACTION_BITS;
            default:            st_next[0].val = 64'sd0;
        endcase
    end

    // divider stages, the first one also rounds the product
    for (genvar k = 1; k < Stages; k++)
    begin : g_div
        logic [63:0] pmag;
        logic [63:0] pround;
        logic [34:0] trial;
        logic [33:0] rem_w;
        logic [31:0] num_w;

        always_comb
        begin
            st_next[k] = st_reg[k-1];
            rem_w      = st_reg[k-1].rem;
            num_w      = st_reg[k-1].num;
            pmag       = st_reg[k-1].val[63] ? (~st_reg[k-1].val + 64'd1)
                                             : st_reg[k-1].val;
            pround     = (pmag + Half) >> FRACTION_BITS;
            trial      = '0;
            for (int s = 0; s < StepsPerStage; s++)
            begin
                trial = {rem_w, num_w[31]};
                num_w = {num_w[30:0], 1'b0};
                if (trial >= {1'b0, st_reg[k-1].den})
                begin
                    trial    = trial - {1'b0, st_reg[k-1].den};
                    num_w[0] = 1'b1;
                end
                rem_w = trial[33:0];
            end
            st_next[k].rem = rem_w;
            st_next[k].num = num_w;
            if (k == 1 && st_reg[k-1].func == fxa_pkg::FUNC_MUL)
            begin
                st_next[k].val = st_reg[k-1].val[63] ? $signed(~pround + 64'd1)
                                                     : $signed(pround);
            end
        end
    end

    for (genvar k = 0; k < Stages; k++)
    begin : g_pipe
        logic vld_in;
        if (k == 0)
        begin : g_first
            assign vld_in = req.valid;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // final stage: sign of quotient, saturation, status
    stage_t             fin;
    logic signed [31:0] result_next;
    logic               flag_next;
    logic [1:0]         status_next;
    logic signed [31:0] result_reg;
    logic               flag_reg;
    logic [1:0]         status_reg;
    logic               out_vld_reg;

    always_comb
    begin
        fin         = st_reg[Stages-1];
        result_next = 32'sd0;
        flag_next   = 1'b0;
        status_next = fxa_pkg::STATUS_OK;
        unique case (fin.func)
            fxa_pkg::FUNC_DIV:
            begin
                if (fin.div_zero)
                begin
                    status_next = fxa_pkg::STATUS_DIV0;
                end
                else if (fin.neg)
                begin
                    if (fin.div_ovf || fin.num > 32'h8000_0000)
                    begin
                        result_next = Min32[31:0];
                        status_next = fxa_pkg::STATUS_OVF;
                    end
                    else
                    begin
                        result_next = $signed(~fin.num + 32'd1);
                    end
                end
                else if (fin.div_ovf || fin.num[31])
                begin
                    result_next = Max32[31:0];
                    status_next = fxa_pkg::STATUS_OVF;
                end
                else
                begin
                    result_next = $signed(fin.num);
                end
            end
            fxa_pkg::FUNC_GT, fxa_pkg::FUNC_LT, fxa_pkg::FUNC_GE,
            fxa_pkg::FUNC_LE, fxa_pkg::FUNC_EQ, fxa_pkg::FUNC_NE:
            begin
                flag_next = fin.flag;
            end
            default:
            begin
                if (fin.val > Max32)
                begin
                    result_next = Max32[31:0];
                    status_next = fxa_pkg::STATUS_OVF;
                end
                else if (fin.val < Min32)
                begin
                    result_next = Min32[31:0];
                    status_next = fxa_pkg::STATUS_OVF;
                end
                else
                begin
                    result_next = fin.val[31:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vld_reg[Stages-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
            flag_reg   <= flag_next;
            status_reg <= status_next;
        end
    end

    assign rsp.valid  = out_vld_reg;
    assign rsp.result = result_reg;
    assign rsp.flag   = flag_reg;
    assign rsp.status = status_reg;

endmodule

`default_nettype wire

>>> tb/sv/fxa_tb_if.sv
// fxa_tb_pkg: result record shared by the testbench checker
// depends on nothing
`default_nettype none

package fxa_tb_pkg;

    typedef struct packed {
        logic signed [31:0] result;
        logic               flag;
        logic [1:0]         status;
    } alu_out_t;
endpackage

`default_nettype wire

>>> tb/sv/fxa_checker.sv
// fxa_checker: watches both channels, predicts each result and compares
// depends on fxa_pkg, fxa_tb_pkg and the channel interfaces
`default_nettype none

module fxa_checker #(
    parameter int unsigned FRACTION_BITS = fxa_pkg::FractionBitsDefault
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fxa_req_if.sink   req,
    fxa_rsp_if.sink   rsp,
    output int        errors,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    fxa_tb_pkg::alu_out_t expected_q[$];

    function automatic logic signed [63:0] saturate(input logic signed [63:0] v,
                                                      inout logic [1:0] st);
        if (v > 64'sd2147483647) begin
            st = fxa_pkg::STATUS_OVF;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            st = fxa_pkg::STATUS_OVF;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic fxa_tb_pkg::alu_out_t compute_alu(input logic [3:0] fn,
                                                         input logic signed [31:0] opa,
                                                         input logic signed [31:0] opb);
        logic signed [63:0] a, b, r, p;
        logic [63:0] mag, n, d, q, half;
        logic [1:0] st;
        logic fl;
        fxa_tb_pkg::alu_out_t o;
        a = opa;
        b = opb;
        r = 0;
        fl = 1'b0;
        st = fxa_pkg::STATUS_OK;
        half = (64'd1 << FRACTION_BITS) >> 1;
        case (fxa_pkg::func_t'(fn))
            fxa_pkg::FUNC_ADD: r = a + b;
            fxa_pkg::FUNC_SUB: r = a - b;
            fxa_pkg::FUNC_MUL:
            begin
                p = a * b;
                mag = ((p < 0 ? -p : p) + half) >> FRACTION_BITS;
                r = p < 0 ? -$signed(mag) : $signed(mag);
            end
            fxa_pkg::FUNC_DIV:
            begin
                if (b == 0)
                begin
                    st = fxa_pkg::STATUS_DIV0;
                end
                else
                begin
                    n = (a < 0 ? -a : a) << FRACTION_BITS;
                    d = b < 0 ? -b : b;
                    q = (2 * n + d) / (2 * d);
                    r = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
                end
            end
            fxa_pkg::FUNC_GT: fl = a > b;
            fxa_pkg::FUNC_LT: fl = a < b;
            fxa_pkg::FUNC_GE: fl = a >= b;
            fxa_pkg::FUNC_LE: fl = a <= b;
            fxa_pkg::FUNC_EQ: fl = a == b;
            fxa_pkg::FUNC_NE: fl = a != b;
            fxa_pkg::FUNC_MIN: r = a < b ? a : b;
            fxa_pkg::FUNC_MAX: r = a > b ? a : b;
            fxa_pkg::FUNC_INC: r = a + 1;
            fxa_pkg::FUNC_DEC: r = a - 1;
            fxa_pkg::FUNC_FINT: r = a * (64'sd1 <<< FRACTION_BITS);
            default: r = 0;
        endcase
        if (st == fxa_pkg::STATUS_OK)
            r = saturate(r, st);
        o.result = r[31:0];
        o.flag = fl;
        o.status = st;
        return o;
    endfunction

    initial errors = 0;
    initial pending = 0;

    always @(posedge clk)
    begin
        fxa_tb_pkg::alu_out_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                expected_q.push_back(compute_alu(req.func, req.operand_a, req.operand_b));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result transfer: result %h flag %b status %0d",
                                 rsp.result, rsp.flag, rsp.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.result !== rsp.result || want.flag !== rsp.flag
                        || want.status !== rsp.status)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
                                     want.result, want.flag, want.status,
                                     rsp.result, rsp.flag, rsp.status);
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: stimulus and verdict for fixed_point_alu
// depends on fxa_pkg, the channel interfaces and fxa_checker
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems = 900;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   quiet_cycles = 0;
    bit   stimulus_done = 1'b0;
    bit   calm = 1'b0;

    fxa_req_if req ();
    fxa_rsp_if rsp ();

    fixed_point_alu uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    fxa_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                     .errors(errors), .pending(pending));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        req.valid = 1'b0;
        req.func = fxa_pkg::FUNC_ADD;
        req.operand_a = '0;
        req.operand_b = '0;
        rsp.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // interesting operand values: the range limits, zero, within 3 lsb of zero, small and 16-bit ranges
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $signed(32'($urandom_range(0, 6)) - 32'd3);
            4: return $signed(32'($urandom_range(0, 1024)) - 32'd512);
            5: return $signed(32'($urandom_range(0, 65535)) - 32'd32768);
            6: return $signed({{16{$urandom_range(0, 1) == 1}}, 16'($urandom)});
            default: return $signed(32'($urandom));
        endcase
    endfunction

    // sink side: random stall bursts, none once calm
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 18);
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // one transfer on req, valid stays high across back-to-back items
    task automatic send_item(input logic [3:0] fn, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        req.valid <= 1'b1;
        req.func <= fn;
        req.operand_a <= a;
        req.operand_b <= b;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic maybe_idle();
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 18);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic signed [31:0] vmax, vmin, one;
        vmax = 32'sh7fffffff;
        vmin = 32'sh80000000;
        one = 32'sd1 <<< fxa_pkg::FractionBitsDefault;
        @(posedge rst_n);
        @(posedge clk);
        // directed: limits, every func, saturation, divide by zero, rounding ties
        send_item(fxa_pkg::FUNC_ADD, vmax, 32'sd1);
        send_item(fxa_pkg::FUNC_SUB, vmin, 32'sd1);
        send_item(fxa_pkg::FUNC_MUL, vmax, vmax);
        send_item(fxa_pkg::FUNC_MUL, vmin, vmin);
        send_item(fxa_pkg::FUNC_MUL, 32'sd128, 32'sd1);
        send_item(fxa_pkg::FUNC_MUL, -32'sd128, 32'sd1);
        send_item(fxa_pkg::FUNC_DIV, one, 32'sd0);
        send_item(fxa_pkg::FUNC_DIV, vmin, -32'sd1);
        send_item(fxa_pkg::FUNC_DIV, 32'sd1, 32'sd2 * one);
        send_item(fxa_pkg::FUNC_DIV, -32'sd3, one * 32'sd2);
        send_item(fxa_pkg::FUNC_GT, vmax, vmin);
        send_item(fxa_pkg::FUNC_LT, vmin, vmax);
        send_item(fxa_pkg::FUNC_GE, 32'sd5, 32'sd5);
        send_item(fxa_pkg::FUNC_LE, 32'sd6, 32'sd5);
        send_item(fxa_pkg::FUNC_EQ, vmin, vmin);
        send_item(fxa_pkg::FUNC_NE, vmin, vmin);
        send_item(fxa_pkg::FUNC_MIN, 32'sd7, 32'sd7);
        send_item(fxa_pkg::FUNC_MAX, vmin, vmax);
        send_item(fxa_pkg::FUNC_INC, vmax, 32'sd0);
        send_item(fxa_pkg::FUNC_DEC, vmin, 32'sd0);
        send_item(fxa_pkg::FUNC_FINT, 32'sh00800000, 32'sd0);
        send_item(fxa_pkg::FUNC_FINT, -32'sh00800001, 32'sd0);
        send_item(fxa_pkg::FUNC_NOP, vmax, vmin);
        send_item(fxa_pkg::FUNC_FINT, -32'sd1, -32'sd1);
        for (int i = 0; i < RandomItems; i++)
        begin
            if (i == RandomItems * 3 / 4)
                calm = 1'b1;
            maybe_idle();
            send_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
        end
        req.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("FAIL fixed_point_alu");
            $finish;
        end
    end

    initial
    begin
        wait (stimulus_done);
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("PASS fixed_point_alu");
        else
            $display("FAIL fixed_point_alu");
        $finish;
    end
endmodule

`default_nettype wire
